// File: rtl/scqf_pkg.sv
// Shared constants, codes and control types of the sparse CAR quadratic form block.
// No dependencies; the interfaces, the multiply unit and the top level use this package.
package scqf_pkg;

  localparam int SITES   = 1024;
  localparam int SITE_AW = $clog2(SITES);

  localparam int REQ_W  = 2;
  localparam int SITE_W = 10;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 16;
  localparam int RHO_W  = 17;
  localparam int DATA_W = 64;

  localparam int A_W    = VAL_W + 1;
  localparam int B_W    = 35;
  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = PROD_W + VAL_W;

  localparam int DIAG_SHIFT = 24;
  localparam int NBR_SHIFT  = 8;
  localparam int FIN_SHIFT  = 17;
  localparam int FIN_SCALE  = 16;
  localparam int RHO_SCALE  = 9;

  localparam logic [RHO_W-1:0]         RHO_RESET = RHO_W'(65536);
  localparam logic [B_W-1:0]           DIAG_BIAS = B_W'(1 << 24);
  localparam logic signed [DATA_W-1:0] SAT_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_TRIP = 2'd1,
    REQ_FIN  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI,
    ACC_FIN_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_DIAG,
    SH_NBR,
    SH_FIN
  } shift_e;

  typedef struct packed {
    acc_op_e acc_op;
    logic    sat_en;
    shift_e  shift;
  } mac_ctrl_t;

endpackage

// File: rtl/scqf_if.sv
// Request and result channel interfaces of the quadratic form block.
// Depends on scqf_pkg for field widths.
interface scqf_req_if;
  logic                                valid;
  logic                                ready;
  logic [scqf_pkg::REQ_W-1:0]          req_type;
  logic [scqf_pkg::SITE_W-1:0]         site;
  logic [scqf_pkg::SITE_W-1:0]         neighbour_site;
  logic signed [scqf_pkg::VAL_W-1:0]   phi_value;
  logic signed [scqf_pkg::VAL_W-1:0]   theta_value;
  logic [scqf_pkg::WGT_W-1:0]          weight_sum;
  logic [scqf_pkg::WGT_W-1:0]          weight;

  modport source (
    output valid, req_type, site, neighbour_site, phi_value, theta_value, weight_sum, weight,
    input  ready
  );
  modport sink (
    input  valid, req_type, site, neighbour_site, phi_value, theta_value, weight_sum, weight,
    output ready
  );
endinterface

interface scqf_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [scqf_pkg::DATA_W-1:0] form_value;
  logic                               overflow;

  modport source (output valid, form_value, overflow, input ready);
  modport sink   (input  valid, form_value, overflow, output ready);
endinterface

// File: rtl/scqf_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module scqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/scqf_mac.sv
// Shared multiply unit with wide accumulator, scaling shift and 64-bit saturation.
// Depends on scqf_pkg for widths, shift amounts and the control struct.
module scqf_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  scqf_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [scqf_pkg::A_W-1:0]    a_i,
  input  logic signed [scqf_pkg::B_W-1:0]    b_i,
  input  logic signed [scqf_pkg::DATA_W-1:0] base_i,
  output logic signed [scqf_pkg::PROD_W-1:0] prod_o,
  output logic signed [scqf_pkg::DATA_W-1:0] term_o,
  output logic                               term_sat_o
);
  import scqf_pkg::*;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  base_ext;
  logic signed [DATA_W-1:0] term_d, term_q;
  logic                     fits;
  logic                     term_sat_q;

  assign prod_d   = PROD_W'(a_i) * PROD_W'(b_i);
  assign base_ext = {{(ACC_W-DATA_W-FIN_SCALE){base_i[DATA_W-1]}}, base_i, {FIN_SCALE{1'b0}}};

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD:    acc_d = {{VAL_W{prod_q[PROD_W-1]}}, prod_q};
      ACC_ADD_HI:  acc_d = acc_q + {prod_q, {VAL_W{1'b0}}};
      ACC_FIN_SUB: acc_d = base_ext - acc_q;
      default:     acc_d = acc_q;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.shift)
      SH_DIAG: shifted = acc_q >>> DIAG_SHIFT;
      SH_NBR:  shifted = acc_q >>> NBR_SHIFT;
      default: shifted = acc_q >>> FIN_SHIFT;
    endcase
    fits   = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
    term_d = fits ? shifted[DATA_W-1:0] : (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q     <= '0;
      acc_q      <= '0;
      term_q     <= '0;
      term_sat_q <= 1'b0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      if (ctrl_i.sat_en) begin
        term_q     <= term_d;
        term_sat_q <= !fits;
      end
    end
  end

  assign prod_o     = prod_q;
  assign term_o     = term_q;
  assign term_sat_o = term_sat_q;

endmodule

// File: rtl/sparse_car_quadratic_form.sv
// Sparse CAR quadratic form engine: top level with sequencer, site stores and sums.
// Depends on scqf_pkg, scqf_if, scqf_ram and scqf_mac.
//
// Items are taken one at a time: the request channel is ready only when the sequencer
// is idle. A finish item also waits for the result register to free up, and a self triplet
// or unknown request is dropped while the sequencer stays idle. The steps are set by the
// single shared 33x35 multiplier, which forms the site product and then the two halves of
// its scaled term, followed by saturation and accumulation.
// Site values sit in two single-port RAMs written by load items and read by triplets;
// a triplet naming a site that was never loaded yields an undefined term. The result
// register holds a finished value while the next items are taken.
module sparse_car_quadratic_form (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scqf_pkg::RHO_W-1:0]      cfg_wdata_i,
  scqf_req_if.sink                        req_i,
  scqf_res_if.source                      res_o
);
  import scqf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD0,
    S_LD1,
    S_TR0,
    S_CAP,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_FIN_SUB,
    S_SAT,
    S_ADD,
    S_OUT
  } state_e;

  state_e                   state_d, state_q;
  req_e                     op_d, op_q;
  logic [RHO_W-1:0]         rho_d, rho_q;
  logic signed [VAL_W-1:0]  ph_d, ph_q, th_d, th_q;
  logic [WGT_W-1:0]         s_d, s_q, w_d, w_q;
  logic signed [DATA_W-1:0] x_d, x_q;
  logic [B_W-1:0]           y_d, y_q;
  logic signed [DATA_W-1:0] dsum_d, dsum_q, nsum_d, nsum_q;
  logic                     flag_d, flag_q;
  logic                     out_valid_d, out_valid_q;
  logic signed [DATA_W-1:0] form_d, form_q;
  logic                     ovf_d, ovf_q;

  logic                     in_fire;
  logic                     out_load;
  req_e                     in_req;
  logic [SITE_AW-1:0]       row_addr, col_addr, theta_addr;
  logic                     store_we;
  logic [VAL_W-1:0]         phi_rd, theta_rd;
  mac_ctrl_t                mac_ctrl;
  logic signed [A_W-1:0]    mac_a;
  logic signed [B_W-1:0]    mac_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] term;
  logic                     term_sat;
  logic signed [DATA_W-1:0] add_base;
  logic signed [DATA_W:0]   add_sum;
  logic                     add_sat;
  logic signed [DATA_W-1:0] add_res;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign in_req      = req_e'(req_i.req_type);
  assign row_addr    = SITE_AW'(req_i.site);
  assign col_addr    = SITE_AW'(req_i.neighbour_site);
  assign theta_addr  = (in_req == REQ_LOAD) ? row_addr : col_addr;
  assign store_we    = in_fire && (in_req == REQ_LOAD);
  assign out_load    = !out_valid_q || res_o.ready;

  scqf_ram #(.WIDTH(VAL_W), .DEPTH(SITES)) u_phi_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (row_addr),
    .wdata_i (req_i.phi_value),
    .rdata_o (phi_rd)
  );

  scqf_ram #(.WIDTH(VAL_W), .DEPTH(SITES)) u_theta_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (theta_addr),
    .wdata_i (req_i.theta_value),
    .rdata_o (theta_rd)
  );

  scqf_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .base_i     (dsum_q),
    .prod_o     (prod),
    .term_o     (term),
    .term_sat_o (term_sat)
  );

  assign add_base = (op_q == REQ_LOAD) ? dsum_q : nsum_q;
  assign add_sum  = {add_base[DATA_W-1], add_base} + {term[DATA_W-1], term};
  assign add_sat  = add_sum[DATA_W] != add_sum[DATA_W-1];
  assign add_res  = add_sat ? (add_sum[DATA_W] ? SAT_MIN : SAT_MAX) : add_sum[DATA_W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rho_d       = cfg_we_i ? cfg_wdata_i : rho_q;
    ph_d        = ph_q;
    th_d        = th_q;
    s_d         = s_q;
    w_d         = w_q;
    x_d         = x_q;
    y_d         = y_q;
    dsum_d      = dsum_q;
    nsum_d      = nsum_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !res_o.ready;
    form_d      = form_q;
    ovf_d       = ovf_q;
    mac_a       = '0;
    mac_b       = '0;
    mac_ctrl.acc_op = ACC_HOLD;
    mac_ctrl.sat_en = 1'b0;
    unique case (op_q)
      REQ_LOAD: mac_ctrl.shift = SH_DIAG;
      REQ_TRIP: mac_ctrl.shift = SH_NBR;
      default:  mac_ctrl.shift = SH_FIN;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d = in_req;
          ph_d = req_i.phi_value;
          th_d = req_i.theta_value;
          s_d  = req_i.weight_sum;
          w_d  = req_i.weight;
          unique case (in_req)
            REQ_LOAD: state_d = S_LD0;
            REQ_TRIP: begin
              if (row_addr != col_addr) begin
                state_d = S_TR0;
              end
            end
            REQ_FIN: begin
              x_d     = nsum_q;
              y_d     = B_W'(rho_q);
              state_d = S_MUL_LO;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LD0: begin
        mac_a   = A_W'(rho_q);
        mac_b   = B_W'(s_q);
        state_d = S_LD1;
      end
      S_LD1: begin
        mac_a   = A_W'(ph_q);
        mac_b   = B_W'(th_q);
        y_d     = prod[B_W-1:0] - B_W'({rho_q, {RHO_SCALE{1'b0}}}) + DIAG_BIAS;
        state_d = S_CAP;
      end
      S_TR0: begin
        mac_a   = {phi_rd[VAL_W-1], phi_rd};
        mac_b   = {{(B_W-VAL_W){theta_rd[VAL_W-1]}}, theta_rd};
        y_d     = B_W'(w_q);
        state_d = S_CAP;
      end
      S_CAP: begin
        x_d     = prod[DATA_W-1:0];
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        mac_a   = {1'b0, x_q[VAL_W-1:0]};
        mac_b   = y_q;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        mac_a           = {x_q[DATA_W-1], x_q[DATA_W-1:VAL_W]};
        mac_b           = y_q;
        mac_ctrl.acc_op = ACC_LOAD;
        state_d         = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.acc_op = ACC_ADD_HI;
        state_d         = (op_q == REQ_FIN) ? S_FIN_SUB : S_SAT;
      end
      S_FIN_SUB: begin
        mac_ctrl.acc_op = ACC_FIN_SUB;
        state_d         = S_SAT;
      end
      S_SAT: begin
        mac_ctrl.sat_en = 1'b1;
        state_d         = (op_q == REQ_FIN) ? S_OUT : S_ADD;
      end
      S_ADD: begin
        if (op_q == REQ_LOAD) begin
          dsum_d = add_res;
        end else begin
          nsum_d = add_res;
        end
        flag_d  = flag_q || term_sat || add_sat;
        state_d = S_IDLE;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          form_d      = term;
          ovf_d       = flag_q || term_sat;
          dsum_d      = '0;
          nsum_d      = '0;
          flag_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= REQ_NONE;
      rho_q       <= RHO_RESET;
      ph_q        <= '0;
      th_q        <= '0;
      s_q         <= '0;
      w_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      dsum_q      <= '0;
      nsum_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      form_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rho_q       <= rho_d;
      ph_q        <= ph_d;
      th_q        <= th_d;
      s_q         <= s_d;
      w_q         <= w_d;
      x_q         <= x_d;
      y_q         <= y_d;
      dsum_q      <= dsum_d;
      nsum_q      <= nsum_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      form_q      <= form_d;
      ovf_q       <= ovf_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.form_value = form_q;
  assign res_o.overflow   = ovf_q;

  a_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == S_IDLE))
    else $error("site store written while an item is in flight");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result beat raised outside the output step");

  a_clear_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_load) |=> (dsum_q == '0 && nsum_q == '0 && !flag_q))
    else $error("sums not cleared after a finish");

  a_add_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> ($past(state_q) == S_SAT && op_q != REQ_FIN))
    else $error("accumulation without a fresh saturated term");

endmodule
